>>> rtl/min_variance_laplacian_edge_defines.svh
// assertion macros shared by the edge detector rtl
`ifndef MIN_VARIANCE_LAPLACIAN_EDGE_DEFINES_SVH
`define MIN_VARIANCE_LAPLACIAN_EDGE_DEFINES_SVH
`ifndef SYNTHESIS
`define MVLE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("mvle assertion failed");
`define MVLE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("mvle next-cycle assertion failed");
`else
`define MVLE_ASSERT(label, clk, rst_n, prop)
`define MVLE_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/mvle_pkg.sv
// types and constants of the minimum-variance laplacian edge detector
package mvle_pkg;
	localparam int PIX_W = 8;
	localparam int SUM_W = 12;
	localparam int ROW_W = 13;
	localparam int THR_W = 8;
	localparam int CW_W = 10;
	localparam int CH_W = 13;
	localparam int MIN_DIM = 3;
	localparam int MAX_HEIGHT = 4096;
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W = 3;
	localparam int QCNT_W = 4;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [THR_W-1:0] THR_RESET = 8'd20;
	localparam logic [CW_W-1:0] WIDTH_RESET = 10'd512;
	localparam logic [CH_W-1:0] HEIGHT_RESET = 13'd512;
	localparam logic [PIX_W-1:0] PIX_EDGE = 8'd0;
	localparam logic [PIX_W-1:0] PIX_FLAT = 8'd255;
	localparam logic OP_PIXEL = 1'b0;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WIDTH = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic left;
		logic wrap;
		logic top;
		logic bot;
	} clamp_t;

	typedef struct packed {
		logic vld;
		logic emit;
		logic last;
		clamp_t cl;
	} bk_ctl_t;

	typedef struct packed {
		logic is_edge;
		logic last;
	} result_t;
endpackage

>>> rtl/mvle_channels.sv
// stream channel interfaces for pixels in and edge map out
interface mvle_in_if;
	logic valid;
	logic ready;
	logic op;
	logic [mvle_pkg::PIX_W-1:0] pixel_in;
	modport source (output valid, op, pixel_in, input ready);
	modport sink (input valid, op, pixel_in, output ready);
endinterface

interface mvle_out_if;
	logic valid;
	logic ready;
	logic [mvle_pkg::PIX_W-1:0] pixel_out;
	logic frame_end;
	modport source (output valid, pixel_out, frame_end, input ready);
	modport sink (input valid, pixel_out, frame_end, output ready);
endinterface

>>> rtl/min_variance_laplacian_edge.sv
// top level of the minimum-variance laplacian zero-crossing edge detector
// video channel: one transaction per pixel (op pixel) or drain tick (op flush), raster order.
// edge_map channel: one transaction per image pixel, 0 on an edge and 255 elsewhere;
// frame_end marks the last pixel of a frame.
// the first result of a frame follows pixel 2*W+2; the last 2*W+2 results each need one
// more video transaction (flush, or a pixel that is ignored) after the last pixel.
// throughput: one video transaction per cycle while ready is high; each line store is read
// at one column and written at another in the same cycle, so a pixel never waits on it.
// after the transaction that releases it, a result passes through five pipeline registers
// and then the result queue before it shows on edge_map.
// the result queue holds eight entries; when edge_map stalls, video keeps taking
// transactions until eight results are owed, then ready drops.
// frame width and height are latched on the first pixel of a frame; the threshold
// is taken when the result is formed.
// reset clears the frame state, the queue and the registers; line stores are not cleared.
// apb registers: threshold at 0x0, width at 0x4, height at 0x8.
`include "min_variance_laplacian_edge_defines.svh"
module min_variance_laplacian_edge #(
	parameter int MAX_WIDTH = 512
) (
	input logic clk,
	input logic arst_n,
	mvle_in_if.sink video,
	mvle_out_if.source edge_map,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [mvle_pkg::ADDR_W-1:0] paddr,
	input logic [mvle_pkg::DATA_W-1:0] pwdata,
	output logic [mvle_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int CNW = mvle_pkg::QCNT_W;

	logic [mvle_pkg::THR_W-1:0] thr_q;
	logic [mvle_pkg::CW_W-1:0] width_q;
	logic [mvle_pkg::CH_W-1:0] height_q;
	logic [CNW-1:0] occ_q;
	mvle_pkg::reg_idx_t idx;
	logic wr_en, accept, emit_step, pop, push, head_valid;
	mvle_pkg::bk_ctl_t ctl_s3;
	logic [CW-1:0] nc_s3;
	logic [mvle_pkg::SUM_W-1:0] sum_s3;
	mvle_pkg::result_t push_data, head_data;

	assign pready = 1'b1;
	assign idx = mvle_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mvle_pkg::THR_RESET;
			width_q <= mvle_pkg::WIDTH_RESET;
			height_q <= mvle_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				mvle_pkg::REG_THRESHOLD: thr_q <= pwdata[mvle_pkg::THR_W-1:0];
				mvle_pkg::REG_WIDTH: width_q <= pwdata[mvle_pkg::CW_W-1:0];
				mvle_pkg::REG_HEIGHT: height_q <= pwdata[mvle_pkg::CH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mvle_pkg::REG_THRESHOLD: prdata = (mvle_pkg::DATA_W)'(thr_q);
			mvle_pkg::REG_WIDTH: prdata = (mvle_pkg::DATA_W)'(width_q);
			mvle_pkg::REG_HEIGHT: prdata = (mvle_pkg::DATA_W)'(height_q);
			default: prdata = '0;
		endcase
	end

	// results owed: counted at acceptance, released when edge_map takes them
	assign video.ready = (occ_q < CNW'(mvle_pkg::QUEUE_DEPTH));
	assign accept = video.valid && video.ready;
	assign pop = edge_map.valid && edge_map.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + CNW'(emit_step) - CNW'(pop);
		end
	end

	mvle_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.op(video.op),
		.pixel_in(video.pixel_in),
		.cfg_width(width_q),
		.cfg_height(height_q),
		.emit_step(emit_step),
		.ctl_s3(ctl_s3),
		.nc_s3(nc_s3),
		.sum_s3(sum_s3)
	);

	mvle_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_s3(ctl_s3),
		.nc_s3(nc_s3),
		.sum_s3(sum_s3),
		.thr(thr_q),
		.push(push),
		.push_data(push_data)
	);

	mvle_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.head_valid(head_valid),
		.head_data(head_data)
	);

	assign edge_map.valid = head_valid;
	assign edge_map.pixel_out = head_data.is_edge ? mvle_pkg::PIX_EDGE : mvle_pkg::PIX_FLAT;
	assign edge_map.frame_end = head_data.last;

	`MVLE_ASSERT(a_occ_bound, clk, arst_n, occ_q <= CNW'(mvle_pkg::QUEUE_DEPTH))
	`MVLE_ASSERT(a_valid_owed, clk, arst_n, !edge_map.valid || (occ_q != '0))
	`MVLE_ASSERT_NEXT(a_emit_owed, clk, arst_n, emit_step, occ_q != '0)
endmodule

>>> rtl/mvle_front.sv
// frame sequencing, pixel line store, pixel window and laplacian sum
module mvle_front #(
	parameter int MAX_WIDTH = 512
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic op,
	input logic [mvle_pkg::PIX_W-1:0] pixel_in,
	input logic [mvle_pkg::CW_W-1:0] cfg_width,
	input logic [mvle_pkg::CH_W-1:0] cfg_height,
	output logic emit_step,
	output mvle_pkg::bk_ctl_t ctl_s3,
	output logic [$clog2(MAX_WIDTH)-1:0] nc_s3,
	output logic [mvle_pkg::SUM_W-1:0] sum_s3
);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = $clog2(2 * MAX_WIDTH + 3);
	localparam int RW = mvle_pkg::ROW_W;
	localparam int PW = mvle_pkg::PIX_W;
	localparam int SW = mvle_pkg::SUM_W;

	logic busy_q;
	logic [WW-1:0] fw_q;
	logic [RW-1:0] fh_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [LW-1:0] cnt_q;

	logic [WW-1:0] w_sat, fw;
	logic [RW-1:0] h_sat, fh, pr;
	logic [CW-1:0] pc, nc, fw_m1;
	logic [LW-1:0] cnt, lag;
	logic step, emit, last, col_end;
	mvle_pkg::clamp_t pcl, bcl;

	logic [2*PW-1:0] pmem [MAX_WIDTH];
	logic [2*PW-1:0] prd_s1;
	logic v_s1;
	logic [PW-1:0] pix_s1;
	logic [CW-1:0] pc_s1, nc_s1, nc_s2;
	mvle_pkg::clamp_t pcl_s1, pcl_s2;
	mvle_pkg::bk_ctl_t bctl_s1, bctl_s2;
	logic [PW-1:0] wcol_q [3][3];
	logic [PW-1:0] col_top, col_bot;
	logic [PW-1:0] sel [3][3];
	logic [SW-1:0] corners, edges, centre, sum;

	always_comb begin
		if (cfg_width < (mvle_pkg::CW_W)'(mvle_pkg::MIN_DIM)) begin
			w_sat = WW'(mvle_pkg::MIN_DIM);
		end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
			w_sat = WW'(MAX_WIDTH);
		end else begin
			w_sat = WW'(cfg_width);
		end
		if (cfg_height < (mvle_pkg::CH_W)'(mvle_pkg::MIN_DIM)) begin
			h_sat = RW'(mvle_pkg::MIN_DIM);
		end else if (32'(cfg_height) > 32'(mvle_pkg::MAX_HEIGHT)) begin
			h_sat = RW'(mvle_pkg::MAX_HEIGHT);
		end else begin
			h_sat = RW'(cfg_height);
		end
		fw = busy_q ? fw_q : w_sat;
		fh = busy_q ? fh_q : h_sat;
		pc = busy_q ? col_q : '0;
		pr = busy_q ? row_q : '0;
		cnt = busy_q ? cnt_q : '0;
		fw_m1 = CW'(fw - WW'(1));
		lag = LW'({fw, 1'b0}) + LW'(2);
		emit = (cnt == lag);
		last = (pr == fh + RW'(2)) && (pc == CW'(1));
		col_end = (WW'(pc) + WW'(1) == fw);
		step = accept && ((op == mvle_pkg::OP_PIXEL) || (busy_q && !(pr < fh)));
		pcl.left = (pc == CW'(1));
		pcl.wrap = (pc == '0);
		pcl.top = (pr == RW'(1));
		pcl.bot = (pr >= fh);
		bcl.left = (pc == CW'(2));
		bcl.wrap = (pc == CW'(1));
		bcl.top = ((pc != '0) && (pr == RW'(2))) || ((pc == '0) && (pr == RW'(3)));
		bcl.bot = ((pc != '0) && (pr >= fh + RW'(1))) || ((pc == '0) && (pr >= fh + RW'(2)));
		nc = (pc == '0) ? fw_m1 : pc - CW'(1);
		emit_step = step && emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fw_q <= '0;
			fh_q <= '0;
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
		end else if (step) begin
			fw_q <= fw;
			fh_q <= fh;
			if (last) begin
				busy_q <= 1'b0;
				col_q <= '0;
				row_q <= '0;
				cnt_q <= '0;
			end else begin
				busy_q <= 1'b1;
				if (col_end) begin
					col_q <= '0;
					row_q <= pr + RW'(1);
				end else begin
					col_q <= pc + CW'(1);
					row_q <= pr;
				end
				cnt_q <= emit ? cnt : cnt + LW'(1);
			end
		end
	end

	// line store word: high byte row above, low byte two rows above
	always_ff @(posedge clk) begin
		if (step) begin
			prd_s1 <= pmem[pc];
		end
		if (v_s1) begin
			pmem[pc_s1] <= {pix_s1, prd_s1[2*PW-1:PW]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			bctl_s1 <= '0;
			bctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			v_s1 <= step;
			bctl_s1 <= '{vld: step, emit: emit, last: last, cl: bcl};
			bctl_s2 <= bctl_s1;
			ctl_s3 <= bctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pixel_in;
		pc_s1 <= pc;
		pcl_s1 <= pcl;
		nc_s1 <= nc;
		pcl_s2 <= pcl_s1;
		nc_s2 <= nc_s1;
		nc_s3 <= nc_s2;
		sum_s3 <= sum;
	end

	always_comb begin
		col_top = pcl_s1.top ? prd_s1[2*PW-1:PW] : prd_s1[PW-1:0];
		col_bot = pcl_s1.bot ? prd_s1[2*PW-1:PW] : pix_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			wcol_q[0] <= wcol_q[1];
			wcol_q[1] <= wcol_q[2];
			wcol_q[2][0] <= col_top;
			wcol_q[2][1] <= prd_s1[2*PW-1:PW];
			wcol_q[2][2] <= col_bot;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sel[0][r] = pcl_s2.left ? wcol_q[1][r] : wcol_q[0][r];
			sel[1][r] = wcol_q[1][r];
			sel[2][r] = pcl_s2.wrap ? wcol_q[1][r] : wcol_q[2][r];
		end
		corners = SW'(sel[0][0]) + SW'(sel[2][0]) + SW'(sel[0][2]) + SW'(sel[2][2]);
		edges = SW'(sel[1][0]) + SW'(sel[1][2]) + SW'(sel[0][1]) + SW'(sel[2][1]);
		centre = SW'(sel[1][1]);
		sum = (corners << 1) - edges - (centre << 2);
	end
endmodule

>>> rtl/mvle_back.sv
// sum line store, sum window, classification and zero-crossing decision
module mvle_back #(
	parameter int MAX_WIDTH = 512
) (
	input logic clk,
	input logic arst_n,
	input mvle_pkg::bk_ctl_t ctl_s3,
	input logic [$clog2(MAX_WIDTH)-1:0] nc_s3,
	input logic [mvle_pkg::SUM_W-1:0] sum_s3,
	input logic [mvle_pkg::THR_W-1:0] thr,
	output logic push,
	output mvle_pkg::result_t push_data
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = mvle_pkg::SUM_W;

	logic [2*SW-1:0] smem [MAX_WIDTH];
	logic [2*SW-1:0] srd_s4;
	mvle_pkg::bk_ctl_t ctl_s4, ctl_s5;
	logic [CW-1:0] nc_s4;
	logic [SW-1:0] sum_s4;
	logic [SW-1:0] swin_q [3][3];
	logic [SW-1:0] col_top, col_bot;
	logic [SW-1:0] sel [3][3];
	logic [SW-1:0] t3, neg_t3;
	logic centre_pos, any_neg;

	always_ff @(posedge clk) begin
		if (ctl_s3.vld) begin
			srd_s4 <= smem[nc_s3];
		end
		if (ctl_s4.vld) begin
			smem[nc_s4] <= {sum_s4, srd_s4[2*SW-1:SW]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		nc_s4 <= nc_s3;
		sum_s4 <= sum_s3;
	end

	always_comb begin
		col_top = ctl_s4.cl.top ? srd_s4[2*SW-1:SW] : srd_s4[SW-1:0];
		col_bot = ctl_s4.cl.bot ? srd_s4[2*SW-1:SW] : sum_s4;
	end

	always_ff @(posedge clk) begin
		if (ctl_s4.vld) begin
			swin_q[0] <= swin_q[1];
			swin_q[1] <= swin_q[2];
			swin_q[2][0] <= col_top;
			swin_q[2][1] <= srd_s4[2*SW-1:SW];
			swin_q[2][2] <= col_bot;
		end
	end

	always_comb begin
		t3 = SW'({thr, 1'b0}) + SW'(thr);
		neg_t3 = -t3;
		any_neg = 1'b0;
		for (int r = 0; r < 3; r++) begin
			sel[0][r] = ctl_s5.cl.left ? swin_q[1][r] : swin_q[0][r];
			sel[1][r] = swin_q[1][r];
			sel[2][r] = ctl_s5.cl.wrap ? swin_q[1][r] : swin_q[2][r];
		end
		// a positive class wins over a negative one when the threshold is zero
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				any_neg = any_neg | (($signed(sel[c][r]) <= $signed(neg_t3))
					&& ($signed(sel[c][r]) < $signed(t3)));
			end
		end
		centre_pos = $signed(sel[1][1]) >= $signed(t3);
		push = ctl_s5.vld && ctl_s5.emit;
		push_data.is_edge = centre_pos && any_neg;
		push_data.last = ctl_s5.last;
	end
endmodule

>>> rtl/mvle_queue.sv
// result queue between the datapath and the output channel
`include "min_variance_laplacian_edge_defines.svh"
module mvle_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mvle_pkg::result_t push_data,
	input logic pop,
	output logic head_valid,
	output mvle_pkg::result_t head_data
);
	localparam int QD = mvle_pkg::QUEUE_DEPTH;
	localparam int PTW = mvle_pkg::QPTR_W;
	localparam int CNW = mvle_pkg::QCNT_W;

	mvle_pkg::result_t q_mem [QD];
	logic [PTW-1:0] wr_q, rd_q;
	logic [CNW-1:0] cnt_q;
	logic do_pop;

	assign head_valid = (cnt_q != '0);
	assign head_data = q_mem[rd_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PTW'(1);
			end
			cnt_q <= cnt_q + CNW'(push) - CNW'(do_pop);
		end
	end

	`MVLE_ASSERT(a_no_push_full, clk, arst_n, !(push && (cnt_q == CNW'(QD))))
	`MVLE_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNW'(QD))
endmodule
